FILE: design/cdq_pkg.sv
// Shared types, constants and pointer helpers for the circular deque.
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int MAX_DEPTH = 1024;
  localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 3;
  localparam int CFG_W     = 11;
  localparam int EXT_W     = (CFG_W > CNT_W) ? CFG_W : CNT_W;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] data_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK       = 3'd4
  } cmd_t;

  // One accepted request as the controller hands it to the store and output stage.
  typedef struct packed {
    logic  valid;
    logic  we;
    idx_t  waddr;
    data_t wdata;
    idx_t  front_addr;
    idx_t  rear_addr;
    logic  ok;
    logic  empty;
    logic  full;
  } req_t;

  function automatic idx_t step_up(idx_t i, cnt_t cap);
    cnt_t nx;
    nx = CNT_W'(i) + CNT_W'(1);
    return (nx >= cap) ? '0 : IDX_W'(nx);
  endfunction

  function automatic idx_t step_down(idx_t i, cnt_t cap);
    cnt_t cm1;
    cm1 = cap - CNT_W'(1);
    return (i == '0 || CNT_W'(i) > cap) ? IDX_W'(cm1) : i - IDX_W'(1);
  endfunction

endpackage

FILE: design/cdq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module cdq_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/cdq_ctrl.sv
// Deque pointer/count/capacity registers and per-request address generation.
`timescale 1ns / 1ps

module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [CMD_W-1:0] command,
  input  data_t            value,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output req_t             req
);

  idx_t head_r, head_nxt;
  idx_t tail_r, tail_nxt;
  cnt_t count_r, count_nxt;
  cnt_t cap_r, cap_nxt;

  logic full, empty;
  logic ok;
  logic we;
  idx_t waddr;

  logic [EXT_W-1:0] cfg_ext;

  assign full  = (count_r >= cap_r);
  assign empty = (count_r == '0);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    ok        = 1'b0;
    we        = 1'b0;
    waddr     = tail_r;
    unique case (cmd_t'(command))
      CMD_PUSH_FRONT: begin
        if (!full) begin
          head_nxt  = step_down(head_r, cap_r);
          waddr     = head_nxt;
          we        = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          ok        = 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        if (!full) begin
          waddr     = tail_r;
          tail_nxt  = step_up(tail_r, cap_r);
          we        = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          ok        = 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (!empty) begin
          head_nxt  = step_up(head_r, cap_r);
          count_nxt = count_r - CNT_W'(1);
          ok        = 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (!empty) begin
          tail_nxt  = step_down(tail_r, cap_r);
          count_nxt = count_r - CNT_W'(1);
          ok        = 1'b1;
        end
      end
      CMD_PEEK: begin
        ok = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // Capacity write: zero reads as one, anything past the store depth clamps.
  always_comb begin
    cfg_ext = EXT_W'(cfg_wdata);
    if (cfg_ext == '0) begin
      cap_nxt = CNT_W'(1);
    end else if (cfg_ext > EXT_W'(MAX_DEPTH)) begin
      cap_nxt = CNT_W'(MAX_DEPTH);
    end else begin
      cap_nxt = CNT_W'(cfg_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      cap_r   <= CNT_W'(MAX_DEPTH);
    end else if (cfg_we) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      cap_r   <= cap_nxt;
    end else if (accept) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_comb begin
    req.valid      = accept && !cfg_we;
    req.we         = accept && !cfg_we && we;
    req.waddr      = waddr;
    req.wdata      = value;
    req.front_addr = head_nxt;
    req.rear_addr  = step_down(tail_nxt, cap_r);
    req.ok         = ok;
    req.empty      = (count_nxt == '0);
    req.full       = (count_nxt >= cap_r);
  end

endmodule

FILE: design/cdq_out.sv
// Result stage: registers flags, forwards same-cycle writes, forces -1 when empty.
`timescale 1ns / 1ps

module cdq_out
  import cdq_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  req_t  req,
  input  data_t front_rdata,
  input  data_t rear_rdata,
  output logic  strobe,
  output logic  ok,
  output data_t front_value,
  output data_t rear_value,
  output logic  is_empty,
  output logic  is_full
);

  logic  valid_r;
  logic  ok_r;
  logic  empty_r;
  logic  full_r;
  logic  fhit_r;
  logic  rhit_r;
  data_t fwd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      ok_r    <= req.ok;
      empty_r <= req.empty;
      full_r  <= req.full;
      fhit_r  <= req.we && (req.waddr == req.front_addr);
      rhit_r  <= req.we && (req.waddr == req.rear_addr);
      fwd_r   <= req.wdata;
    end
  end

  assign strobe      = valid_r;
  assign ok          = ok_r;
  assign is_empty    = empty_r;
  assign is_full     = full_r;
  assign front_value = empty_r ? '1 : (fhit_r ? fwd_r : front_rdata);
  assign rear_value  = empty_r ? '1 : (rhit_r ? fwd_r : rear_rdata);

endmodule

FILE: design/circular_deque_top.sv
// Top level of the circular deque: controller, mirrored entry store, result stage.
//
// Usage
//   Request channel: drive in_command / in_value and raise start; the request is
//   taken at a rising edge with start high and busy low. busy follows cfg_we, so
//   no request is taken at a capacity write edge; otherwise one per cycle.
//   Result channel: exactly one result per request, shown for one cycle with
//   out_strobe high, in the cycle after the request edge. The receiver cannot stall.
//   Throughput 1 request per cycle while busy is low. The pace is set by the
//   entry store: each request writes one entry and reads front and rear at the
//   same edge; the registered read data plus a one-entry write bypass form the
//   result in the next cycle.
//   Config: cfg_we with cfg_wdata loads the capacity (0 reads as 1, above the
//   depth clamps) and empties the queue. Write only while no result is pending.
//   Reset (rst_n low, synchronous): queue empty, capacity at full depth, no
//   result pending. The store itself is not cleared; only written entries are
//   ever read back.
//   The store is kept as two copies written alike, one read port for the front
//   entry and one for the rear entry.
`timescale 1ns / 1ps

module circular_deque_top
  import cdq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         in_command,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_strobe,
  output logic                     out_ok,
  output logic signed [DATA_W-1:0] out_front_value,
  output logic signed [DATA_W-1:0] out_rear_value,
  output logic                     out_is_empty,
  output logic                     out_is_full,
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_wdata
);

  req_t  req;
  data_t front_rdata;
  data_t rear_rdata;
  data_t front_q;
  data_t rear_q;
  logic  accept;

  // A capacity write clears the queue at its edge, so a request there waits.
  assign busy   = cfg_we;
  assign accept = start && !busy;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .command   (in_command),
    .value     (data_t'(in_value)),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req)
  );

  // Front-read copy of the store.
  cdq_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DEPTH)) u_ram_front (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.waddr),
    .wdata (req.wdata),
    .raddr (req.front_addr),
    .rdata (front_rdata)
  );

  // Rear-read copy of the store.
  cdq_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DEPTH)) u_ram_rear (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.waddr),
    .wdata (req.wdata),
    .raddr (req.rear_addr),
    .rdata (rear_rdata)
  );

  // Read data reflects the entry before this edge's write; the result stage
  // substitutes the new value when the addresses match.
  cdq_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req),
    .front_rdata (front_rdata),
    .rear_rdata  (rear_rdata),
    .strobe      (out_strobe),
    .ok          (out_ok),
    .front_value (front_q),
    .rear_value  (rear_q),
    .is_empty    (out_is_empty),
    .is_full     (out_is_full)
  );

  assign out_front_value = $signed(front_q);
  assign out_rear_value  = $signed(rear_q);

endmodule

FILE: design/cdq_checker.sv
// Port-level checker for the circular deque, bound to the top level.
`timescale 1ns / 1ps

module cdq_checker
  import cdq_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic [CMD_W-1:0]         in_command,
  input logic                     out_strobe,
  input logic                     out_ok,
  input logic signed [DATA_W-1:0] out_front_value,
  input logic signed [DATA_W-1:0] out_rear_value,
  input logic                     out_is_empty,
  input logic                     out_is_full,
  input logic                     cfg_we
);

  logic req_take;
  assign req_take = start && !busy && !cfg_we;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    req_take |=> out_strobe)
    else $error("request not answered in the next cycle");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !req_take |=> !out_strobe)
    else $error("result without a request");

  a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_is_empty) |-> (out_front_value == -1 && out_rear_value == -1))
    else $error("empty queue must report -1 for front and rear");

  a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_is_empty && out_is_full))
    else $error("queue reported both empty and full");

  a_peek_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (req_take && in_command == CMD_PEEK) |=> out_ok)
    else $error("peek must always succeed");

endmodule

bind circular_deque_top cdq_checker u_cdq_checker (.*);

FILE: tb/deque_status_check.sv
// Checker for the circular deque: mirrors the queue and compares every result.
`timescale 1ns / 1ps

module deque_status_check
  import cdq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic [CMD_W-1:0]         in_command,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     out_strobe,
  input  logic                     out_ok,
  input  logic signed [DATA_W-1:0] out_front_value,
  input  logic signed [DATA_W-1:0] out_rear_value,
  input  logic                     out_is_empty,
  input  logic                     out_is_full,
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_wdata,
  output int                       mismatches,
  output int                       outstanding,
  output int                       results_seen,
  output int                       pushes_refused,
  output int                       pops_refused,
  output int                       full_hits
);

  typedef struct packed {
    logic  ok;
    data_t front;
    data_t rear;
    logic  empty;
    logic  full;
  } deque_status_t;

  data_t         slots [MAX_DEPTH];
  int            cap_now;
  idx_t          head_ptr;
  idx_t          tail_ptr;
  int            live_count;
  deque_status_t pending_status [$];
  int            errs;
  int            seen;
  int            push_no;
  int            pop_no;
  int            full_no;

  assign mismatches     = errs;
  assign results_seen   = seen;
  assign pushes_refused = push_no;
  assign pops_refused   = pop_no;
  assign full_hits      = full_no;

  function automatic idx_t wrap_up(idx_t i);
    int n;
    n = int'(i) + 1;
    return (n >= cap_now) ? '0 : idx_t'(n);
  endfunction

  // out-of-range pointer (left over from a larger capacity) lands on the top slot
  function automatic idx_t wrap_down(idx_t i);
    return (i == '0 || int'(i) > cap_now) ? idx_t'(cap_now - 1) : i - 1'b1;
  endfunction

  function automatic deque_status_t apply_command(logic [CMD_W-1:0] cmd, data_t val);
    deque_status_t s;
    logic          was_full;
    logic          was_empty;
    was_full  = (live_count >= cap_now);
    was_empty = (live_count == 0);
    s.ok = 1'b0;
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (!was_full) begin
          head_ptr = wrap_down(head_ptr);
          slots[head_ptr] = val;
          live_count++;
          s.ok = 1'b1;
        end else begin
          push_no++;
        end
      end
      CMD_PUSH_BACK: begin
        if (!was_full) begin
          slots[tail_ptr] = val;
          tail_ptr = wrap_up(tail_ptr);
          live_count++;
          s.ok = 1'b1;
        end else begin
          push_no++;
        end
      end
      CMD_POP_FRONT: begin
        if (!was_empty) begin
          head_ptr = wrap_up(head_ptr);
          live_count--;
          s.ok = 1'b1;
        end else begin
          pop_no++;
        end
      end
      CMD_POP_BACK: begin
        if (!was_empty) begin
          tail_ptr = wrap_down(tail_ptr);
          live_count--;
          s.ok = 1'b1;
        end else begin
          pop_no++;
        end
      end
      CMD_PEEK: s.ok = 1'b1;
      default: ;
    endcase
    if (live_count != 0) begin
      s.front = slots[head_ptr];
      s.rear  = slots[wrap_down(tail_ptr)];
    end else begin
      s.front = '1;
      s.rear  = '1;
    end
    s.empty = (live_count == 0);
    s.full  = (live_count >= cap_now);
    if (s.full) full_no++;
    return s;
  endfunction

  task automatic report_mismatch(string what, data_t got, data_t want);
    errs++;
    if (errs <= 100) $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    deque_status_t want;
    int            cap_word;
    if (!rst_n) begin
      cap_now    = MAX_DEPTH;
      head_ptr   = '0;
      tail_ptr   = '0;
      live_count = 0;
      pending_status.delete();
    end else begin
      // result of the previous request leaves before the new one is predicted
      if (out_strobe === 1'b1) begin
        seen++;
        if (pending_status.size() == 0) begin
          report_mismatch("result with no request pending", out_front_value, '1);
        end else begin
          want = pending_status.pop_front();
          if (out_ok !== want.ok)
            report_mismatch("ok", data_t'(out_ok), data_t'(want.ok));
          if (out_front_value !== want.front)
            report_mismatch("front_value", out_front_value, want.front);
          if (out_rear_value !== want.rear)
            report_mismatch("rear_value", out_rear_value, want.rear);
          if (out_is_empty !== want.empty)
            report_mismatch("is_empty", data_t'(out_is_empty), data_t'(want.empty));
          if (out_is_full !== want.full)
            report_mismatch("is_full", data_t'(out_is_full), data_t'(want.full));
        end
      end
      if (cfg_we === 1'b1) begin
        cap_word = int'(cfg_wdata);
        if (cap_word == 0) cap_word = 1;
        if (cap_word > MAX_DEPTH) cap_word = MAX_DEPTH;
        cap_now    = cap_word;
        head_ptr   = '0;
        tail_ptr   = '0;
        live_count = 0;
      end
      if (start === 1'b1 && busy === 1'b0)
        pending_status.push_back(apply_command(in_command, in_value));
    end
    outstanding <= pending_status.size();
  end

endmodule

FILE: tb/tb.sv
// Testbench top for the circular deque: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
  import cdq_pkg::*;

  // no progress for this many cycles means the block has hung
  localparam int STALL_LIMIT = 500;
  // share of cycles in which the request side holds back
  localparam int IDLE_PCT    = 32;

  // command codes the block does not define; they must change nothing
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  // capacity words: all-zero reads as one slot, all-ones clamps to full depth
  localparam logic [CFG_W-1:0] CAP_ALL_ZERO = '0;
  localparam logic [CFG_W-1:0] CAP_ALL_ONES = '1;

  localparam data_t VAL_MIN = 32'h8000_0000;
  localparam data_t VAL_MAX = 32'h7FFF_FFFF;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [CMD_W-1:0]         in_command;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_strobe;
  logic                     out_ok;
  logic signed [DATA_W-1:0] out_front_value;
  logic signed [DATA_W-1:0] out_rear_value;
  logic                     out_is_empty;
  logic                     out_is_full;
  logic                     cfg_we;
  logic [CFG_W-1:0]         cfg_wdata;

  int mismatches;
  int outstanding;
  int results_seen;
  int pushes_refused;
  int pops_refused;
  int full_hits;

  int idle_pct;
  int requests_sent  = 0;
  int caps_written   = 0;
  int quiet_cycles   = 0;

  circular_deque_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_value        (in_value),
    .out_strobe      (out_strobe),
    .out_ok          (out_ok),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  // Predicts every result from the requests and config writes it sees and
  // compares it with what the block shows.
  deque_status_check status_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_value        (in_value),
    .out_strobe      (out_strobe),
    .out_ok          (out_ok),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_seen    (results_seen),
    .pushes_refused  (pushes_refused),
    .pops_refused    (pops_refused),
    .full_hits       (full_hits)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: any accepted request or result counts as progress. Config
  // pauses and idle runs are far shorter than the limit.
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_strobe === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: nothing accepted for %0d cycles", quiet_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Mostly random words, with the extremes and the all-ones word (which looks
  // like the empty marker) showing up often.
  function automatic data_t pick_value();
    case ($urandom_range(0, 9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // One request. Idle cycles go first, with junk on the payload while start
  // is low. Inputs only move at the falling edge; busy is sampled at the
  // rising edge, so the request is taken at the first edge that sees it low.
  task automatic send_request(logic [CMD_W-1:0] cmd, data_t val);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start      <= 1'b0;
      in_command <= CMD_W'($urandom);
      in_value   <= $urandom;
      @(posedge clk);
    end
    @(negedge clk);
    start      <= 1'b1;
    in_command <= cmd;
    in_value   <= val;
    do @(posedge clk); while (busy !== 1'b0);
    requests_sent++;
  endtask

  // Drop start, let every predicted result drain, and give the registered
  // result stage time to show its last result.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Capacity writes only happen with the block idle; each one empties the queue.
  task automatic write_capacity(logic [CFG_W-1:0] word);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= word;
    @(negedge clk);
    cfg_we    <= 1'b0;
    caps_written++;
  endtask

  // Random commands: push_pct pushes, pops up to 94, then peeks, then a few
  // undefined codes.
  task automatic random_phase(int count, int push_pct);
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < push_pct)
        send_request($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_value());
      else if (r < 94)
        send_request($urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT, pick_value());
      else if (r < 97)
        send_request(CMD_PEEK, pick_value());
      else
        send_request(CMD_UNUSED_LO + 3'($urandom_range(0, 2)), pick_value());
    end
  endtask

  logic [CFG_W-1:0] cap_plan [8];

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_command = CMD_PEEK;
    in_value   = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    idle_pct   = IDLE_PCT;
    cap_plan   = '{11'd2, 11'd3, 11'd5, 11'd1, 11'd16, 11'd1025, 11'd1000, 11'd40};
    cap_plan[7] = 11'($urandom_range(6, 64));

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed, at the reset capacity: everything on an empty queue first,
    // including an undefined code, then pushes of the extreme words from both
    // ends (push front from slot zero wraps to the top slot), then drain.
    send_request(CMD_PEEK, '0);
    send_request(CMD_POP_FRONT, '0);
    send_request(CMD_POP_BACK, '0);
    send_request(CMD_UNUSED_LO, VAL_MAX);
    send_request(CMD_PUSH_FRONT, VAL_MIN);
    send_request(CMD_PUSH_BACK, VAL_MAX);
    send_request(CMD_PUSH_FRONT, '1);
    send_request(CMD_PUSH_BACK, '0);
    send_request(CMD_PEEK, '1);
    send_request(CMD_UNUSED_HI, VAL_MIN);
    send_request(CMD_POP_FRONT, '0);
    send_request(CMD_POP_BACK, '0);
    send_request(CMD_POP_FRONT, '0);
    send_request(CMD_POP_BACK, '0);
    send_request(CMD_POP_BACK, '0);

    // Zero capacity is taken as one slot: single entry makes it full, so the
    // next pushes from either end are refused.
    write_capacity(CAP_ALL_ZERO);
    send_request(CMD_PUSH_BACK, 32'h5555_5555);
    send_request(CMD_PUSH_FRONT, 32'h1234_5678);
    send_request(CMD_PUSH_BACK, 32'h1234_5678);
    send_request(CMD_UNUSED_LO + 3'd1, '0);
    send_request(CMD_POP_FRONT, '0);
    send_request(CMD_POP_FRONT, '0);
    send_request(CMD_PUSH_FRONT, 32'hAAAA_AAAA);
    send_request(CMD_POP_BACK, '0);

    // Random mixes over a spread of capacities, small ones mostly so both
    // full and empty come up often; the bias is drawn per phase.
    foreach (cap_plan[k]) begin
      write_capacity(cap_plan[k]);
      random_phase(80, $urandom_range(30, 64));
    end

    // All-ones word clamps to full depth. Fill it with almost only pushes and
    // no idling, so the pointers wrap and pushes meet a full queue.
    write_capacity(CAP_ALL_ONES);
    idle_pct = 0;
    random_phase(1200, 93);
    idle_pct = IDLE_PCT;

    // Back to the exact full depth with a plain mix.
    write_capacity(11'd1024);
    random_phase(60, 50);

    settle();

    $display("%0d requests over %0d capacity settings, %0d results checked",
             requests_sent, caps_written, results_seen);
    $display("%0d pushes refused when full, %0d pops refused when empty, %0d full results",
             pushes_refused, pops_refused, full_hits);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: circular_deque_top.f
design/cdq_pkg.sv
design/cdq_ram.sv
design/cdq_ctrl.sv
design/cdq_out.sv
design/circular_deque_top.sv
design/cdq_checker.sv
tb/deque_status_check.sv
tb/tb.sv
